// File: sv/can_rx_id_filter_fifo_assert.svh
// ----------------------------------------------------------------------------
// CAN receive filter FIFO assertion macros
// Concurrent assertion wrappers shared by the RTL modules.
// ----------------------------------------------------------------------------
`ifndef CAN_RX_ID_FILTER_FIFO_ASSERT_SVH
`define CAN_RX_ID_FILTER_FIFO_ASSERT_SVH

// same-cycle implication
`define CANRXF_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define CANRXF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: sv/canrxf_pkg.sv
// ----------------------------------------------------------------------------
// CAN receive filter FIFO package
// Field widths, operation codes, register defaults and control structs.
// ----------------------------------------------------------------------------
package canrxf_pkg;

   localparam int FUNC_W     = 2;
   localparam int ID_W       = 11;
   localparam int LEN_W      = 4;
   localparam int DATA_W     = 64;
   localparam int DROP_W     = 16;
   localparam int FILL_W     = 4;
   localparam int NUM_BYTES  = 8;
   localparam int MAX_LEN    = 8;
   localparam int NUM_ACCEPT = 6;
   localparam int CSR_IDX_W  = 3;
   localparam int SLOT_W     = ID_W + LEN_W + DATA_W;

   localparam logic [FUNC_W-1:0] FUNC_QUERY = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_STORE = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_POP   = 2'd2;

   localparam logic [DROP_W-1:0] DROP_MAX = 16'hFFFF;

   localparam logic [ID_W-1:0] ACCEPT_RESET [NUM_ACCEPT] = '{
      11'h101, 11'h200, 11'h201, 11'h202, 11'h212, 11'h222
   };

   typedef struct packed {
      logic latch_req;
      logic exec;
      logic load_rsp;
      logic load_pop;
   } cmd_type;

   typedef struct packed {
      logic pop_hit;
   } sts_type;

endpackage

// File: sv/canrxf_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module canrxf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/canrxf_ctrl.sv
// ----------------------------------------------------------------------------
// CAN receive filter FIFO controller
// Sequences accept, execute and pop read-out; drives the response strobe.
// ----------------------------------------------------------------------------
`include "can_rx_id_filter_fifo_assert.svh"

module canrxf_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  canrxf_pkg::sts_type sts,
   output canrxf_pkg::cmd_type cmd,
   output logic               rsp_valid
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_EXEC = 2'd1;
   localparam logic [1:0] ST_POP  = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = 1'b0;
      cmd          = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.latch_req = 1'b1;
               state_in      = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            if (sts.pop_hit) begin
               state_in = ST_POP;
            end else begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_POP: begin
            cmd.load_pop = 1'b1;
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   `CANRXF_ASSERT_NEXT(a_start_exec, clock, reset, start && !busy, state_ff == ST_EXEC, "accepted transfer did not enter execute")
   `CANRXF_ASSERT_IMPL(a_rsp_idle, clock, reset, rsp_valid_ff, state_ff == ST_IDLE, "response strobe outside idle")

endmodule

// File: sv/canrxf_dp.sv
// ----------------------------------------------------------------------------
// CAN receive filter FIFO datapath
// Acceptance filter, ring pointers, drop counter, slot RAM and response.
// ----------------------------------------------------------------------------
`include "can_rx_id_filter_fifo_assert.svh"

module canrxf_dp #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  canrxf_pkg::cmd_type                  cmd,
   output canrxf_pkg::sts_type                  sts,
   input  logic                                 csr_valid,
   input  logic [canrxf_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [canrxf_pkg::ID_W-1:0]          csr_wdata,
   input  logic [canrxf_pkg::FUNC_W-1:0]        req_func,
   input  logic [canrxf_pkg::ID_W-1:0]          req_frame_id,
   input  logic [canrxf_pkg::LEN_W-1:0]         req_frame_len,
   input  logic [canrxf_pkg::DATA_W-1:0]        req_frame_data,
   output logic                                 rsp_id_allowed,
   output logic                                 rsp_stored,
   output logic                                 rsp_dropped_full,
   output logic                                 rsp_popped,
   output logic [canrxf_pkg::ID_W-1:0]          rsp_out_id,
   output logic [canrxf_pkg::LEN_W-1:0]         rsp_out_len,
   output logic [canrxf_pkg::DATA_W-1:0]        rsp_out_data,
   output logic [canrxf_pkg::DROP_W-1:0]        rsp_drop_total,
   output logic [canrxf_pkg::FILL_W-1:0]        rsp_fill_level
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   logic [canrxf_pkg::ID_W-1:0]   accept_ff [canrxf_pkg::NUM_ACCEPT];

   logic [canrxf_pkg::FUNC_W-1:0] func_ff;
   logic [canrxf_pkg::ID_W-1:0]   id_ff;
   logic [canrxf_pkg::LEN_W-1:0]  len_ff;
   logic [canrxf_pkg::DATA_W-1:0] data_ff;

   logic [PTR_W-1:0]              wp_ff, wp_in, rp_ff, rp_in;
   logic [canrxf_pkg::DROP_W-1:0] drop_ff, drop_in;

   logic                          match;
   logic                          is_store, full, pop_hit, wr_en, rd_en;
   logic [canrxf_pkg::LEN_W-1:0]  len_c;
   logic [canrxf_pkg::DATA_W-1:0] data_m;
   logic [canrxf_pkg::SLOT_W-1:0] wr_word, rd_word;
   logic [PTR_W:0]                fill_in;
   logic [PTR_W+4:0]              fill_wide;

   logic                          allowed_ff, stored_ff, dropped_ff, popped_ff;
   logic [canrxf_pkg::ID_W-1:0]   out_id_ff;
   logic [canrxf_pkg::LEN_W-1:0]  out_len_ff;
   logic [canrxf_pkg::DATA_W-1:0] out_data_ff;
   logic [canrxf_pkg::DROP_W-1:0] drop_total_ff;
   logic [canrxf_pkg::FILL_W-1:0] fill_ff;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : PTR_W'(p + 1'b1);
   endfunction

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < canrxf_pkg::NUM_ACCEPT; k++) begin
            accept_ff[k] <= canrxf_pkg::ACCEPT_RESET[k];
         end
      end else if (csr_valid) begin
         for (int k = 0; k < canrxf_pkg::NUM_ACCEPT; k++) begin
            if (csr_index == canrxf_pkg::CSR_IDX_W'(k)) begin
               accept_ff[k] <= csr_wdata;
            end
         end
      end
   end

   // request capture
   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         func_ff <= req_func;
         id_ff   <= req_frame_id;
         len_ff  <= req_frame_len;
         data_ff <= req_frame_data;
      end
   end

   always_comb begin
      match = 1'b0;
      for (int k = 0; k < canrxf_pkg::NUM_ACCEPT; k++) begin
         if (accept_ff[k] == id_ff) begin
            match = 1'b1;
         end
      end
   end

   assign is_store = (func_ff == canrxf_pkg::FUNC_STORE) && match;
   assign full     = (ptr_next(wp_ff) == rp_ff);
   assign pop_hit  = (func_ff == canrxf_pkg::FUNC_POP) && (rp_ff != wp_ff);
   assign wr_en    = cmd.exec && is_store && !full;
   assign rd_en    = cmd.exec && pop_hit;
   assign sts.pop_hit = pop_hit;

   // clamp length, zero unused bytes
   assign len_c = (len_ff > canrxf_pkg::LEN_W'(canrxf_pkg::MAX_LEN)) ?
                  canrxf_pkg::LEN_W'(canrxf_pkg::MAX_LEN) : len_ff;

   always_comb begin
      for (int i = 0; i < canrxf_pkg::NUM_BYTES; i++) begin
         data_m[8*i +: 8] = (canrxf_pkg::LEN_W'(i) < len_c) ? data_ff[8*i +: 8] : 8'h00;
      end
   end

   assign wr_word = {id_ff, len_c, data_m};

   always_comb begin
      wp_in   = wp_ff;
      rp_in   = rp_ff;
      drop_in = drop_ff;
      if (cmd.exec) begin
         if (wr_en) begin
            wp_in = ptr_next(wp_ff);
         end
         if (pop_hit) begin
            rp_in = ptr_next(rp_ff);
         end
         if (is_store && full && (drop_ff != canrxf_pkg::DROP_MAX)) begin
            drop_in = drop_ff + 1'b1;
         end
      end
   end

   always_comb begin
      fill_in = {1'b0, wp_in} - {1'b0, rp_in};
      if (wp_in < rp_in) begin
         fill_in = fill_in + (PTR_W + 1)'(QUEUE_DEPTH);
      end
   end

   assign fill_wide = (PTR_W + 5)'(fill_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff   <= '0;
         rp_ff   <= '0;
         drop_ff <= '0;
      end else begin
         wp_ff   <= wp_in;
         rp_ff   <= rp_in;
         drop_ff <= drop_in;
      end
   end

   canrxf_ram #(
      .WIDTH (canrxf_pkg::SLOT_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wp_ff),
      .wr_data (wr_word),
      .rd_en   (rd_en),
      .rd_addr (rp_ff),
      .rd_data (rd_word)
   );

   // response registers
   always_ff @(posedge clock) begin
      priority if (cmd.load_rsp) begin
         allowed_ff    <= ((func_ff == canrxf_pkg::FUNC_QUERY) ||
                           (func_ff == canrxf_pkg::FUNC_STORE)) && match;
         stored_ff     <= is_store && !full;
         dropped_ff    <= is_store && full;
         popped_ff     <= 1'b0;
         out_id_ff     <= '0;
         out_len_ff    <= '0;
         out_data_ff   <= '0;
         drop_total_ff <= drop_in;
         fill_ff       <= fill_wide[canrxf_pkg::FILL_W-1:0];
      end else if (cmd.load_pop) begin
         allowed_ff    <= 1'b0;
         stored_ff     <= 1'b0;
         dropped_ff    <= 1'b0;
         popped_ff     <= 1'b1;
         out_id_ff     <= rd_word[canrxf_pkg::SLOT_W-1 -: canrxf_pkg::ID_W];
         out_len_ff    <= rd_word[canrxf_pkg::DATA_W +: canrxf_pkg::LEN_W];
         out_data_ff   <= rd_word[canrxf_pkg::DATA_W-1:0];
         drop_total_ff <= drop_ff;
         fill_ff       <= fill_wide[canrxf_pkg::FILL_W-1:0];
      end else begin
      end
   end

   assign rsp_id_allowed   = allowed_ff;
   assign rsp_stored       = stored_ff;
   assign rsp_dropped_full = dropped_ff;
   assign rsp_popped       = popped_ff;
   assign rsp_out_id       = out_id_ff;
   assign rsp_out_len      = out_len_ff;
   assign rsp_out_data     = out_data_ff;
   assign rsp_drop_total   = drop_total_ff;
   assign rsp_fill_level   = fill_ff;

   `CANRXF_ASSERT_IMPL(a_pop_after_read, clock, reset, cmd.load_pop, $past(rd_en), "pop response without slot read")
   `CANRXF_ASSERT_NEXT(a_drop_monotonic, clock, reset, !reset, drop_ff >= $past(drop_ff), "drop counter decreased")
   `CANRXF_ASSERT_IMPL(a_no_write_full, clock, reset, wr_en, ptr_next(wp_ff) != rp_ff && !rd_en, "slot write into full ring")

endmodule

// File: sv/can_rx_id_filter_fifo.sv
// ----------------------------------------------------------------------------
// CAN receive identifier filter with frame FIFO
// Query, store and pop operations on a ring of received frames.
// ----------------------------------------------------------------------------
// The response strobe is registered from the execute state; a pop that
// returns a frame passes through the pop state to wait for the registered
// read port of the slot RAM. A new operation is accepted only while idle.
// Reset (synchronous): clears ring pointers and drop counter, restores the
// accepted identifiers; slot RAM is not cleared. Results cannot be stalled.
module can_rx_id_filter_fifo #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [canrxf_pkg::FUNC_W-1:0]    req_func,
   input  logic [canrxf_pkg::ID_W-1:0]      req_frame_id,
   input  logic [canrxf_pkg::LEN_W-1:0]     req_frame_len,
   input  logic [canrxf_pkg::DATA_W-1:0]    req_frame_data,
   output logic                             rsp_valid,
   output logic                             rsp_id_allowed,
   output logic                             rsp_stored,
   output logic                             rsp_dropped_full,
   output logic                             rsp_popped,
   output logic [canrxf_pkg::ID_W-1:0]      rsp_out_id,
   output logic [canrxf_pkg::LEN_W-1:0]     rsp_out_len,
   output logic [canrxf_pkg::DATA_W-1:0]    rsp_out_data,
   output logic [canrxf_pkg::DROP_W-1:0]    rsp_drop_total,
   output logic [canrxf_pkg::FILL_W-1:0]    rsp_fill_level,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [canrxf_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [canrxf_pkg::ID_W-1:0]      csr_wdata
);

   canrxf_pkg::cmd_type cmd;
   canrxf_pkg::sts_type sts;

   assign csr_ready = 1'b1;

   canrxf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .sts       (sts),
      .cmd       (cmd),
      .rsp_valid (rsp_valid)
   );

   canrxf_dp #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .csr_valid        (csr_valid),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_func         (req_func),
      .req_frame_id     (req_frame_id),
      .req_frame_len    (req_frame_len),
      .req_frame_data   (req_frame_data),
      .rsp_id_allowed   (rsp_id_allowed),
      .rsp_stored       (rsp_stored),
      .rsp_dropped_full (rsp_dropped_full),
      .rsp_popped       (rsp_popped),
      .rsp_out_id       (rsp_out_id),
      .rsp_out_len      (rsp_out_len),
      .rsp_out_data     (rsp_out_data),
      .rsp_drop_total   (rsp_drop_total),
      .rsp_fill_level   (rsp_fill_level)
   );

endmodule
